@@ sv/cht_pkg.sv @@
package cht_pkg;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned PayW    = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned TotalW  = 7;
  localparam int unsigned EmptyW  = 5;
  localparam int unsigned LongW   = 7;
  localparam int unsigned CfgW    = 5;
  localparam logic [CfgW-1:0] BucketCountRst = 5'd15;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 3'd0,
    CMD_SEARCH = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_STATS  = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_MOD     = 11'b00000000010,
    S_WALK    = 11'b00000000100,
    S_CHK     = 11'b00000001000,
    S_ALLOC   = 11'b00000010000,
    S_DELLINK = 11'b00000100000,
    S_DELFREE = 11'b00001000000,
    S_STHEAD  = 11'b00010000000,
    S_STWALK  = 11'b00100000000,
    S_STNEXT  = 11'b01000000000,
    S_SPARE   = 11'b10000000000
  } state_e;

endpackage

@@ sv/chained_hash_table.sv @@
// Chained hash table on a fixed node pool.
// Command channel: a command (cmd_i, key_i, payload_i) transfers on the rising
// edge where start_i is high and busy_o is low. Exactly one result follows,
// shown for one cycle with done_o high; the receiver cannot hold it off.
// Commands: insert (new node at chain head), search, update, delete,
// statistics. Unknown command codes return at once with status ok.
// Operation: the bucket index is key mod bucket count, found by a bit-serial
// restoring divider. The chain walk then reads each visited node from the
// node memories, which have a registered read port. A new insert ends in
// S_ALLOC, a delete in S_DELLINK and S_DELFREE. Statistics visits every bucket
// and every stored node. The strobe comes in the first cycle with busy_o low.
// One command is in flight at a time; busy_o is high while it is.
// Configuration: APB register 0 (byte address 0) holds bucket_count; write it
// only while the block is idle. A count of zero acts as one, a count above
// MAX_BUCKETS as MAX_BUCKETS.
// Reset: all buckets empty, all nodes on the free list, count zero, bucket
// count 15. No clearing pass: per-node valid bits stand in for the free list.
module chained_hash_table
  import cht_pkg::*;
#(
  parameter int unsigned MAX_BUCKETS = 16,
  parameter int unsigned POOL_NODES  = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [CmdW-1:0]    cmd_i,
  input  logic [KeyW-1:0]    key_i,
  input  logic [PayW-1:0]    payload_i,
  output logic               done_o,
  output logic [StatusW-1:0] status_o,
  output logic [PayW-1:0]    found_payload_o,
  output logic [TotalW-1:0]  entry_total_o,
  output logic [EmptyW-1:0]  empty_buckets_o,
  output logic [LongW-1:0]   longest_chain_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned NW  = $clog2(POOL_NODES + 1);
  localparam int unsigned AW  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int unsigned BCW = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam logic [NW-1:0] Nil = NW'(POOL_NODES);
  localparam int unsigned KW  = $clog2(KeyW);

  // configuration
  logic [CfgW-1:0] bcount_q;
  logic [BCW-1:0]  nb;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - CfgW){1'b0}}, bcount_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcount_q <= BucketCountRst;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      bcount_q <= pwdata[CfgW-1:0];
    end
  end

  always_comb begin
    if (bcount_q == '0) begin
      nb = BCW'(1);
    end else if (32'(bcount_q) > MAX_BUCKETS) begin
      nb = BCW'(MAX_BUCKETS);
    end else begin
      nb = BCW'(bcount_q);
    end
  end

  // node memories
  logic [KeyW+PayW-1:0] kp_mem [POOL_NODES];
  logic [NW-1:0]        nx_mem [POOL_NODES];
  logic [POOL_NODES-1:0] nx_vld_q;

  logic                 kp_we, nx_we;
  logic [AW-1:0]        kp_wa, nx_wa, kp_ra, nx_ra;
  logic [KeyW+PayW-1:0] kp_wd, kp_rd_q;
  logic [NW-1:0]        nx_wd, nx_raw_q, rd_next;
  logic                 nx_rvld_q;
  logic [AW-1:0]        nx_raddr_q;

  always_ff @(posedge clk_i) begin
    if (kp_we) begin
      kp_mem[kp_wa] <= kp_wd;
    end
    if (nx_we) begin
      nx_mem[nx_wa] <= nx_wd;
    end
    kp_rd_q  <= kp_mem[kp_ra];
    nx_raw_q <= nx_mem[nx_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_vld_q   <= '0;
      nx_rvld_q  <= 1'b0;
      nx_raddr_q <= '0;
    end else begin
      if (nx_we) begin
        nx_vld_q[nx_wa] <= 1'b1;
      end
      nx_rvld_q  <= nx_vld_q[nx_ra];
      nx_raddr_q <= nx_ra;
    end
  end

  // an unwritten link still holds its free-list value
  assign rd_next = nx_rvld_q ? nx_raw_q : (NW'(nx_raddr_q) + NW'(1));

  // control and datapath
  state_e           state_q, state_d;
  logic [NW-1:0]    head_q [MAX_BUCKETS];
  logic [NW-1:0]    free_q, cur_q, prev_q, steps_q, link_q, len_q, long_q;
  logic [NW-1:0]    entry_q;
  logic [CmdW-1:0]  cmd_q;
  logic [KeyW-1:0]  key_q, shift_q;
  logic [PayW-1:0]  pay_q;
  logic [KW-1:0]    bit_q;
  logic [BCW-1:0]   rem_q, idx_q, empty_q;
  logic [BCW:0]     rem_sh;
  logic [BCW-1:0]   rem_nx;
  logic             done_q;
  logic [StatusW-1:0] status_q;
  logic [PayW-1:0]  found_q;
  logic [NW-1:0]    long_nx;
  logic [BCW-1:0]   empty_nx;

  assign rem_sh = {rem_q, shift_q[KeyW-1]};
  assign rem_nx = (rem_sh >= {1'b0, nb}) ? BCW'(rem_sh - {1'b0, nb}) : BCW'(rem_sh);
  assign long_nx  = (len_q > long_q) ? len_q : long_q;
  assign empty_nx = (len_q == '0) ? empty_q + BCW'(1) : empty_q;

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    kp_we = 1'b0;
    kp_wa = cur_q[AW-1:0];
    kp_wd = {key_q, pay_q};
    nx_we = 1'b0;
    nx_wa = cur_q[AW-1:0];
    nx_wd = free_q;
    kp_ra = cur_q[AW-1:0];
    nx_ra = cur_q[AW-1:0];
    state_d = state_q;
    case (state_q)
      S_WALK: begin
        if ((cur_q == Nil || steps_q == Nil) && cmd_q == CMD_INSERT) begin
          nx_ra = free_q[AW-1:0];
        end
      end
      S_CHK: begin
        if (kp_rd_q[KeyW+PayW-1:PayW] == key_q && cmd_q == CMD_UPDATE) begin
          kp_we = 1'b1;
        end
      end
      S_ALLOC: begin
        kp_we = 1'b1;
        kp_wa = free_q[AW-1:0];
        nx_we = 1'b1;
        nx_wa = free_q[AW-1:0];
        nx_wd = head_q[rem_q[BW-1:0]];
      end
      S_DELLINK: begin
        if (prev_q != Nil) begin
          nx_we = 1'b1;
          nx_wa = prev_q[AW-1:0];
          nx_wd = link_q;
        end
      end
      S_DELFREE: begin
        nx_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      free_q   <= '0;
      entry_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      found_q  <= '0;
      empty_q  <= '0;
      long_q   <= '0;
      for (int i = 0; i < MAX_BUCKETS; i++) begin
        head_q[i] <= Nil;
      end
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cmd_q    <= cmd_i;
            key_q    <= key_i;
            shift_q  <= key_i;
            pay_q    <= payload_i;
            rem_q    <= '0;
            bit_q    <= '0;
            status_q <= ST_OK;
            found_q  <= '0;
            empty_q  <= '0;
            long_q   <= '0;
            idx_q    <= '0;
            if (cmd_i == CMD_STATS) begin
              state_q <= S_STHEAD;
            end else if (cmd_i > CMD_STATS) begin
              done_q <= 1'b1;
            end else begin
              state_q <= S_MOD;
            end
          end
        end
        S_MOD: begin
          rem_q   <= rem_nx;
          shift_q <= shift_q << 1;
          bit_q   <= bit_q + KW'(1);
          if (bit_q == KW'(KeyW - 1)) begin
            cur_q   <= head_q[rem_nx[BW-1:0]];
            prev_q  <= Nil;
            steps_q <= '0;
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (cur_q == Nil || steps_q == Nil) begin
            if (cmd_q != CMD_INSERT) begin
              status_q <= ST_NOTFOUND;
              done_q   <= 1'b1;
              state_q  <= S_IDLE;
            end else if (free_q == Nil) begin
              status_q <= ST_FULL;
              done_q   <= 1'b1;
              state_q  <= S_IDLE;
            end else begin
              state_q <= S_ALLOC;
            end
          end else begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          if (kp_rd_q[KeyW+PayW-1:PayW] == key_q) begin
            link_q  <= rd_next;
            state_q <= S_IDLE;
            done_q  <= 1'b1;
            case (cmd_q)
              CMD_INSERT: status_q <= ST_DUP;
              CMD_SEARCH: found_q  <= kp_rd_q[PayW-1:0];
              CMD_DELETE: begin
                done_q  <= 1'b0;
                state_q <= S_DELLINK;
              end
              default: ;
            endcase
          end else begin
            prev_q  <= cur_q;
            cur_q   <= rd_next;
            steps_q <= steps_q + NW'(1);
            state_q <= S_WALK;
          end
        end
        S_ALLOC: begin
          head_q[rem_q[BW-1:0]] <= free_q;
          free_q  <= rd_next;
          entry_q <= entry_q + NW'(1);
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_DELLINK: begin
          if (prev_q == Nil) begin
            head_q[rem_q[BW-1:0]] <= link_q;
          end
          state_q <= S_DELFREE;
        end
        S_DELFREE: begin
          free_q <= cur_q;
          if (entry_q != '0) begin
            entry_q <= entry_q - NW'(1);
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_STHEAD: begin
          cur_q   <= head_q[idx_q[BW-1:0]];
          len_q   <= '0;
          state_q <= S_STWALK;
        end
        S_STWALK: begin
          if (cur_q == Nil || len_q == Nil) begin
            empty_q <= empty_nx;
            long_q  <= long_nx;
            idx_q   <= idx_q + BCW'(1);
            if (idx_q + BCW'(1) == nb) begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_STHEAD;
            end
          end else begin
            state_q <= S_STNEXT;
          end
        end
        S_STNEXT: begin
          cur_q   <= rd_next;
          len_q   <= len_q + NW'(1);
          state_q <= S_STWALK;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  logic is_stats_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_stats_q <= 1'b0;
    end else if (start_i && !busy_o) begin
      is_stats_q <= (cmd_i == CMD_STATS);
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign found_payload_o = found_q;
  assign entry_total_o   = TotalW'(entry_q);
  assign empty_buckets_o = is_stats_q ? EmptyW'(empty_q) : '0;
  assign longest_chain_o = is_stats_q ? LongW'(long_q) : '0;

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result strobe while a command is running");

  a_busy_after_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i <= CMD_STATS) |=> busy_o)
    else $error("known command did not occupy the block");

  a_free_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q == Nil) |-> (entry_q == Nil)) else $error("free list empty with pool not full");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (entry_q == Nil))
    else $error("table full reported with free nodes");

endmodule
